### hw/rtl/wcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_pkg: shared types and helpers of the weekly channel event scheduler
// Item layouts, action codes and the channel on/off updates of the busy and
// drive registers.
// ----------------------------------------------------------------------------
package wcs_pkg;

	localparam int CHANNELS            = 4;
	localparam int ENTRIES_PER_CHANNEL = 4;
	localparam int SLOTS               = CHANNELS * ENTRIES_PER_CHANNEL;
	localparam int SLOT_W              = $clog2(SLOTS);
	localparam int CNT_W               = $clog2(SLOTS + 1);
	localparam int CH_IDX_W            = 2;
	localparam int NORMAL_BUSY_LSB     = 4;
	localparam logic [15:0] MANUAL_SECS_RESET = 16'd600;

	localparam logic [1:0] CFG_HP_MASK     = 2'd0;
	localparam logic [1:0] CFG_MANUAL_SECS = 2'd1;

	typedef enum logic [2:0] {
		ACT_TICK      = 3'd0,
		ACT_WRITE     = 3'd1,
		ACT_MAN_START = 3'd2,
		ACT_MAN_STOP  = 3'd3,
		ACT_CLEAR     = 3'd4
	} action_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] now_seconds;
		logic [16:0] second_of_day;
		logic [2:0]  weekday;
		logic [2:0]  channel;
		logic [1:0]  entry_index;
		logic [6:0]  entry_day_mask;
		logic [10:0] entry_start_minute;
		logic [15:0] entry_duration;
	} cmd_item_t;

	typedef struct packed {
		logic [3:0] channel_drive;
		logic [7:0] busy_bits;
		logic [2:0] manual_channel;
	} res_item_t;

	typedef struct packed {
		logic [15:0] duration;
		logic [10:0] start_minute;
		logic [6:0]  day_mask;
	} entry_t;

	typedef struct packed {
		logic [7:0] busy;
		logic [3:0] drive;
	} chan_state_t;

	function automatic chan_state_t chan_on(chan_state_t st, logic [CH_IDX_W-1:0] ch0,
			logic hp);
		chan_state_t r;
		logic [2:0]  nb;
		r  = st;
		nb = 3'(NORMAL_BUSY_LSB) + {1'b0, ch0};
		if (hp) begin
			r.busy[{1'b0, ch0}] = 1'b1;
		end else begin
			r.busy[nb] = 1'b1;
		end
		r.drive[ch0] = 1'b1;
		return r;
	endfunction

	function automatic chan_state_t chan_off(chan_state_t st, logic [CH_IDX_W-1:0] ch0);
		chan_state_t r;
		logic [2:0]  nb;
		r  = st;
		nb = 3'(NORMAL_BUSY_LSB) + {1'b0, ch0};
		r.busy[{1'b0, ch0}] = 1'b0;
		r.busy[nb]          = 1'b0;
		r.drive[ch0]        = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/wcs_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_cmd_if: command channel of the scheduler
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface wcs_cmd_if import wcs_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/wcs_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcs_res_if: result channel of the scheduler
// Valid/ready channel carrying one status beat.
// ----------------------------------------------------------------------------
interface wcs_res_if import wcs_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/weekly_channel_event_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weekly_channel_event_scheduler: per-channel weekly schedule table
// Command beats enter on cmd and every command returns one status beat on
// res: the drive levels, the busy bits and the manual channel after it.
// A tick walks the sixteen schedule entries held in two tables, one entry
// read per cycle and the previous entry's run start written back in the
// same cycle, then checks the manual run for its timeout.
// A tick passes through the table reads, a drain of the last read, the manual
// timeout check in S_DONE, the result load in S_EMIT and the return to idle
// before the next acceptance. Every other command goes straight to S_EMIT.
// The result sits in an output register, so a new command is accepted while
// the previous status beat still waits; if res stalls for longer, the block
// holds the next result and stops taking commands until res frees up.
// Reset clears every entry through per-entry valid bits at once, so the
// block is ready in the first cycle after reset. Configuration writes on
// cfg_wr_en must be made only while no command is in flight.
// ----------------------------------------------------------------------------
module weekly_channel_event_scheduler import wcs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	wcs_cmd_if.sink          cmd,
	wcs_res_if.source        res,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [15:0] cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WALK = 4'b0010,
		S_DONE = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_n;

	entry_t      set_mem [SLOTS];
	logic [31:0] run_mem [SLOTS];

	logic [SLOTS-1:0] set_valid_q, set_valid_n;
	logic [SLOTS-1:0] run_valid_q, run_valid_n;

	logic [3:0]  hp_mask_q;
	logic [15:0] manual_secs_q;

	chan_state_t cs_q, cs_n;
	logic [2:0]  man_ch_q, man_ch_n;
	logic [31:0] man_t_q, man_t_n;

	logic [31:0] now_q;
	logic [16:0] sod_q;
	logic [2:0]  wday_q;

	logic [CNT_W-1:0]  cnt_q;
	logic              rd_en;
	logic              vld_s1;
	logic [SLOT_W-1:0] slot_s1;
	entry_t            set_rd_s1;
	logic [31:0]       run_rd_s1;
	logic              sval_s1;
	logic              rval_s1;

	logic              set_we;
	logic [SLOT_W-1:0] set_waddr;
	entry_t            set_wdata;
	logic              run_we;
	logic [31:0]       run_wdata;

	logic      res_valid_q;
	res_item_t res_q;
	logic      res_load;

	logic                cmd_fire;
	logic                ch_ok;
	entry_t              eff_set;
	logic [31:0]         eff_run;
	logic [6:0]          today;
	logic                day_hit;
	logic                time_hit;
	logic [32:0]         run_end;
	logic [32:0]         man_end;
	logic [CH_IDX_W-1:0] slot_ch0;
	logic [CH_IDX_W-1:0] cmd_ch0;
	logic [CH_IDX_W-1:0] man_ch0;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign ch_ok     = (cmd.data.channel >= 3'd1) && (cmd.data.channel <= 3'(CHANNELS));
	assign cmd_ch0   = CH_IDX_W'(cmd.data.channel - 3'd1);
	assign man_ch0   = CH_IDX_W'(man_ch_q - 3'd1);

	assign rd_en    = (state_q == S_WALK) && (cnt_q < CNT_W'(SLOTS));
	assign eff_set  = sval_s1 ? set_rd_s1 : '0;
	assign eff_run  = rval_s1 ? run_rd_s1 : '0;
	assign slot_ch0 = CH_IDX_W'(slot_s1 / ENTRIES_PER_CHANNEL);
	assign today    = 7'd1 << wday_q;
	assign day_hit  = (eff_set.day_mask & today) != 7'd0;
	assign time_hit = sod_q == ({6'd0, eff_set.start_minute} * 17'd60);
	assign run_end  = {1'b0, eff_run} + {17'd0, eff_set.duration};
	assign man_end  = {1'b0, man_t_q} + {17'd0, manual_secs_q};

	assign res_load = (state_q == S_EMIT) && (!res_valid_q || res.ready);

	always_comb begin
		state_n     = state_q;
		cs_n        = cs_q;
		man_ch_n    = man_ch_q;
		man_t_n     = man_t_q;
		set_valid_n = set_valid_q;
		run_valid_n = run_valid_q;
		set_we      = 1'b0;
		set_waddr   = SLOT_W'((32'(cmd.data.channel) - 32'd1) * ENTRIES_PER_CHANNEL
			+ 32'(cmd.data.entry_index));
		set_wdata   = '{duration: cmd.data.entry_duration,
			start_minute: cmd.data.entry_start_minute,
			day_mask: cmd.data.entry_day_mask};
		run_we      = 1'b0;
		run_wdata   = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					state_n = S_EMIT;
					case (cmd.data.action)
						ACT_TICK: begin
							state_n = S_WALK;
						end
						ACT_WRITE: begin
							if (ch_ok && (32'(cmd.data.entry_index) < ENTRIES_PER_CHANNEL)) begin
								set_we                 = 1'b1;
								set_valid_n[set_waddr] = 1'b1;
							end
						end
						ACT_MAN_START: begin
							if (ch_ok && (man_ch_q == 3'd0) && (cs_q.busy[3:0] == 4'd0)) begin
								man_ch_n = cmd.data.channel;
								man_t_n  = cmd.data.now_seconds;
								cs_n     = chan_on(cs_q, cmd_ch0, hp_mask_q[cmd_ch0]);
							end
						end
						ACT_MAN_STOP: begin
							if (man_ch_q != 3'd0) begin
								cs_n = chan_off(cs_q, man_ch0);
							end
							man_ch_n = 3'd0;
							man_t_n  = '0;
						end
						ACT_CLEAR: begin
							cs_n        = '0;
							set_valid_n = '0;
							run_valid_n = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK: begin
				if (vld_s1) begin
					if (eff_run == 32'd0) begin
						if (day_hit && time_hit) begin
							if (man_ch_q != 3'd0) begin
								cs_n = chan_off(cs_n, man_ch0);
							end
							man_ch_n = 3'd0;
							man_t_n  = '0;
							if ((cs_n.busy[3:0] == 4'd0) || !hp_mask_q[slot_ch0]) begin
								run_we               = 1'b1;
								run_wdata            = now_q;
								run_valid_n[slot_s1] = 1'b1;
								cs_n = chan_on(cs_n, slot_ch0, hp_mask_q[slot_ch0]);
							end
						end
					end else if ({1'b0, now_q} > run_end) begin
						run_we               = 1'b1;
						run_wdata            = '0;
						run_valid_n[slot_s1] = 1'b1;
						cs_n = chan_off(cs_n, slot_ch0);
					end
					if (!rd_en) begin
						state_n = S_DONE;
					end
				end
			end
			S_DONE: begin
				if ((man_t_q != 32'd0) && ({1'b0, now_q} > man_end)) begin
					if (man_ch_q != 3'd0) begin
						cs_n = chan_off(cs_q, man_ch0);
					end
					man_ch_n = 3'd0;
					man_t_n  = '0;
				end
				state_n = S_EMIT;
			end
			S_EMIT: begin
				if (res_load) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			set_rd_s1 <= set_mem[cnt_q[SLOT_W-1:0]];
			run_rd_s1 <= run_mem[cnt_q[SLOT_W-1:0]];
		end
		if (set_we) begin
			set_mem[set_waddr] <= set_wdata;
		end
		if (run_we) begin
			run_mem[slot_s1] <= run_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			slot_s1 <= cnt_q[SLOT_W-1:0];
			sval_s1 <= set_valid_q[cnt_q[SLOT_W-1:0]];
			rval_s1 <= run_valid_q[cnt_q[SLOT_W-1:0]];
		end
		if (cmd_fire) begin
			now_q  <= cmd.data.now_seconds;
			sod_q  <= cmd.data.second_of_day;
			wday_q <= cmd.data.weekday;
		end
		if (res_load) begin
			res_q <= '{channel_drive: cs_q.drive, busy_bits: cs_q.busy,
				manual_channel: man_ch_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cs_q          <= '0;
			man_ch_q      <= '0;
			man_t_q       <= '0;
			set_valid_q   <= '0;
			run_valid_q   <= '0;
			hp_mask_q     <= '0;
			manual_secs_q <= MANUAL_SECS_RESET;
			cnt_q         <= '0;
			vld_s1        <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_n;
			cs_q        <= cs_n;
			man_ch_q    <= man_ch_n;
			man_t_q     <= man_t_n;
			set_valid_q <= set_valid_n;
			run_valid_q <= run_valid_n;
			vld_s1      <= rd_en;
			if (cmd_fire) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_idx)
					CFG_HP_MASK:     hp_mask_q     <= cfg_wdata[3:0];
					CFG_MANUAL_SECS: manual_secs_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	a_drive_matches_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cs_q.drive == (cs_q.busy[3:0] | cs_q.busy[7:4]))
		else $error("drive levels disagree with busy bits");

	a_manual_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		man_ch_q <= 3'(CHANNELS))
		else $error("manual channel out of range");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result beat raised outside the emit state");

	a_pipe_only_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_WALK))
		else $error("table read returned outside the walk");

endmodule

`default_nettype wire
